FILE: design/pce_pkg.sv
// Shared types, constants and helper functions of the budget-capped percent encoder.
package pce_pkg;

  localparam int BYTE_W         = 8;
  localparam int BUDGET_W       = 16;
  localparam int COUNT_BITS_DEF = 16;
  localparam int MAX_CHAR       = 4;   // longest UTF-8 character
  localparam int PEND_DEPTH     = 3;   // bytes held of an unfinished character
  localparam int LEN_W          = 3;

  localparam logic [BUDGET_W-1:0] BUDGET_RESET = 16'd6000;

  typedef logic [BYTE_W-1:0] byte_t;

  localparam byte_t PCT_CHAR = 8'h25;
  localparam byte_t NUL_CHAR = 8'h00;

  localparam byte_t HEX_DIGITS [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
  };

  // One item's worth of raw bytes handed to the serializer.
  // nbytes == 0 means an end-only marker.
  typedef struct packed {
    byte_t [MAX_CHAR-1:0] bytes;
    logic  [LEN_W-1:0]    nbytes;
    logic                 done;
  } burst_t;

  typedef struct packed {
    logic             stopped;
    logic [1:0]       pend_cnt;
    logic [LEN_W-1:0] char_len;
  } enc_status_t;

  // UTF-8 length announced by a lead byte; malformed leads count as one.
  function automatic logic [LEN_W-1:0] lead_len(input byte_t c);
    logic [LEN_W-1:0] n;
    n = 3'd1;
    if (c[7] == 1'b0) begin
      n = 3'd1;
    end else if (c[7:5] == 3'b110) begin
      n = 3'd2;
    end else if (c[7:4] == 4'hE) begin
      n = 3'd3;
    end else if (c[7:3] == 5'h1E) begin
      n = 3'd4;
    end
    return n;
  endfunction

  // Unreserved set: letters, digits and - _ . ~
  function automatic logic unreserved(input byte_t c);
    return c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A],
                     8'h2D, 8'h5F, 8'h2E, 8'h7E};
  endfunction

endpackage

FILE: design/pce_in_if.sv
// Input channel: raw string bytes with end-of-string flag.
interface pce_in_if;
  import pce_pkg::*;
  logic  valid;
  logic  ready;
  byte_t in_byte;
  logic  final_byte;
  modport source(output valid, output in_byte, output final_byte, input ready);
  modport sink(input valid, input in_byte, input final_byte, output ready);
endinterface

FILE: design/pce_out_if.sv
// Result channel: encoded output characters with framing flags.
interface pce_out_if;
  import pce_pkg::*;
  logic  valid;
  logic  ready;
  byte_t out_char;
  logic  char_present;
  logic  run_last;
  logic  string_done;
  modport source(output valid, output out_char, output char_present,
                 output run_last, output string_done, input ready);
  modport sink(input valid, input out_char, input char_present,
               input run_last, input string_done, output ready);
endinterface

FILE: design/pce_cfg_if.sv
// Configuration write channel for the output budget register.
interface pce_cfg_if;
  import pce_pkg::*;
  logic                valid;
  logic                ready;
  logic [BUDGET_W-1:0] output_budget;
  modport source(output valid, output output_budget, input ready);
  modport sink(input valid, input output_budget, output ready);
endinterface

FILE: design/pce_encode.sv
// Input register, UTF-8 grouping, budget check and per-string state.
module pce_encode #(
  parameter int COUNT_BITS = pce_pkg::COUNT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  pce_in_if.sink              in_bus,
  pce_cfg_if.sink             cfg_bus,
  input  logic                burst_free,
  output logic                burst_load,
  output pce_pkg::burst_t     burst,
  output pce_pkg::enc_status_t status
);
  import pce_pkg::*;

  localparam int SUM_W      = COUNT_BITS + 1;
  localparam int CMP_W      = (SUM_W > BUDGET_W + 1) ? SUM_W : BUDGET_W + 1;
  localparam int NUM_GROUPS = 3;

  logic                  in_v_r;
  byte_t                 byte_r;
  logic                  fin_r;
  logic [BUDGET_W-1:0]   budget_r;
  logic [COUNT_BITS-1:0] used_r, used_nxt;
  logic                  stopped_r, stopped_nxt;
  logic [1:0]            pend_cnt_r, pend_cnt_nxt;
  logic [LEN_W-1:0]      char_len_r, char_len_nxt;
  byte_t                 pend_r [PEND_DEPTH];

  byte_t                         cand [MAX_CHAR];
  logic [MAX_CHAR-1:0][3:0]      eb;
  logic [LEN_W-1:0]              kk;
  logic                          complete;
  logic                          pair;
  logic [3:0]                    e_all;
  logic [NUM_GROUPS-1:0]         gex;
  logic [NUM_GROUPS-1:0][LEN_W-1:0] gn;
  logic [NUM_GROUPS-1:0][3:0]    ge;
  logic                          active;
  logic [COUNT_BITS-1:0]         u_acc;
  logic [SUM_W-1:0]              grp_sum;
  logic                          run_ok;
  logic                          stop_hit;
  logic [LEN_W-1:0]              m;
  logic                          has_res;
  logic                          xfer;
  logic                          store;

  // candidate character: held bytes followed by the new byte
  always_comb begin
    cand[0] = (pend_cnt_r == 2'd0) ? byte_r : pend_r[0];
    cand[1] = (pend_cnt_r == 2'd1) ? byte_r : pend_r[1];
    cand[2] = (pend_cnt_r == 2'd2) ? byte_r : pend_r[2];
    cand[3] = byte_r;
    for (int i = 0; i < MAX_CHAR; i++) begin
      eb[i] = unreserved(cand[i]) ? 4'd1 : 4'd3;
    end
  end

  assign kk       = {1'b0, pend_cnt_r} + 3'd1;
  assign complete = (pend_cnt_r == 2'd0) ? (lead_len(byte_r) == 3'd1)
                                         : (kk >= char_len_r);
  assign pair     = (kk == 3'd3) && (lead_len(cand[1]) == 3'd2);

  // group split: whole character, or a cut-off character regrouped
  always_comb begin
    e_all = '0;
    for (int i = 0; i < MAX_CHAR; i++) begin
      if (LEN_W'(i) < kk) begin
        e_all = e_all + eb[i];
      end
    end
    if (complete) begin
      gex   = 3'b001;
      gn[0] = kk;
      ge[0] = e_all;
      gn[1] = '0;
      ge[1] = '0;
      gn[2] = '0;
      ge[2] = '0;
    end else begin
      // lead byte alone always, it could not finish its character
      gex[0] = 1'b1;
      gn[0]  = 3'd1;
      ge[0]  = eb[0];
      gex[1] = (kk >= 3'd2);
      gn[1]  = pair ? 3'd2 : 3'd1;
      ge[1]  = eb[1] + (pair ? eb[2] : 4'd0);
      gex[2] = (kk == 3'd3) && !pair;
      gn[2]  = 3'd1;
      ge[2]  = eb[2];
    end
  end

  assign active = in_v_r && !stopped_r && (complete || fin_r);

  // budget test per group, first refusal stops the rest
  always_comb begin
    u_acc    = used_r;
    run_ok   = 1'b1;
    stop_hit = 1'b0;
    m        = '0;
    grp_sum  = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      if (active && gex[g] && run_ok) begin
        grp_sum = {1'b0, u_acc} + SUM_W'(ge[g]);
        if (CMP_W'(grp_sum) > CMP_W'(budget_r)) begin
          stop_hit = 1'b1;
          run_ok   = 1'b0;
        end else begin
          u_acc = grp_sum[COUNT_BITS] ? '1 : grp_sum[COUNT_BITS-1:0];
          m     = m + gn[g];
        end
      end
    end
  end

  assign has_res    = (m != '0) || fin_r;
  assign xfer       = in_v_r && (!has_res || burst_free);
  assign burst_load = in_v_r && has_res && burst_free;
  assign store      = !fin_r && !stopped_r && !complete;

  always_comb begin
    for (int i = 0; i < MAX_CHAR; i++) begin
      burst.bytes[i] = cand[i];
    end
    burst.nbytes = m;
    burst.done   = fin_r;
  end

  assign in_bus.ready  = !in_v_r || xfer;
  assign cfg_bus.ready = 1'b1;

  always_comb begin
    used_nxt     = used_r;
    stopped_nxt  = stopped_r;
    pend_cnt_nxt = pend_cnt_r;
    char_len_nxt = char_len_r;
    if (xfer) begin
      if (fin_r) begin
        used_nxt     = '0;
        stopped_nxt  = 1'b0;
        pend_cnt_nxt = '0;
        char_len_nxt = '0;
      end else if (!stopped_r) begin
        if (complete) begin
          used_nxt     = u_acc;
          stopped_nxt  = stop_hit;
          pend_cnt_nxt = '0;
          char_len_nxt = '0;
        end else begin
          pend_cnt_nxt = kk[1:0];
          if (pend_cnt_r == 2'd0) begin
            char_len_nxt = lead_len(byte_r);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r     <= 1'b0;
      budget_r   <= BUDGET_RESET;
      used_r     <= '0;
      stopped_r  <= 1'b0;
      pend_cnt_r <= '0;
      char_len_r <= '0;
    end else begin
      in_v_r     <= in_bus.valid || (in_v_r && !xfer);
      used_r     <= used_nxt;
      stopped_r  <= stopped_nxt;
      pend_cnt_r <= pend_cnt_nxt;
      char_len_r <= char_len_nxt;
      if (cfg_bus.valid) begin
        budget_r <= cfg_bus.output_budget;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      byte_r <= in_bus.in_byte;
      fin_r  <= in_bus.final_byte;
    end
    if (xfer && store) begin
      case (pend_cnt_r)
        2'd0:    pend_r[0] <= byte_r;
        2'd1:    pend_r[1] <= byte_r;
        2'd2:    pend_r[2] <= byte_r;
        default: ;
      endcase
    end
  end

  assign status.stopped  = stopped_r;
  assign status.pend_cnt = pend_cnt_r;
  assign status.char_len = char_len_r;

endmodule

FILE: design/pce_emit.sv
// Result register and serializer: expands held bytes into output beats.
module pce_emit (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            burst_load,
  input  pce_pkg::burst_t burst,
  output logic            burst_free,
  pce_out_if.source       out_bus
);
  import pce_pkg::*;

  typedef enum logic [1:0] {PH_PCT, PH_HI, PH_LO} phase_t;

  logic                 busy_r;
  byte_t [MAX_CHAR-1:0] bytes_r;
  logic [LEN_W-1:0]     left_r;
  phase_t               phase_r;
  logic                 done_r;

  byte_t cur;
  logic  pass;
  logic  marker;
  logic  byte_end;
  logic  last;
  logic  pop;

  assign cur      = bytes_r[0];
  assign pass     = unreserved(cur);
  assign marker   = (left_r == '0);
  assign byte_end = marker || pass || (phase_r == PH_LO);
  assign last     = byte_end && (left_r <= 3'd1);
  assign pop      = busy_r && out_bus.ready;

  assign burst_free = !busy_r || (pop && last);

  always_comb begin
    out_bus.out_char = cur;
    if (marker) begin
      out_bus.out_char = NUL_CHAR;
    end else if (!pass) begin
      case (phase_r)
        PH_PCT:  out_bus.out_char = PCT_CHAR;
        PH_HI:   out_bus.out_char = HEX_DIGITS[cur[7:4]];
        PH_LO:   out_bus.out_char = HEX_DIGITS[cur[3:0]];
        default: out_bus.out_char = PCT_CHAR;
      endcase
    end
  end

  assign out_bus.valid        = busy_r;
  assign out_bus.char_present = !marker;
  assign out_bus.run_last     = last;
  assign out_bus.string_done  = last && done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      phase_r <= PH_PCT;
    end else if (burst_load) begin
      busy_r  <= 1'b1;
      phase_r <= PH_PCT;
    end else if (pop) begin
      if (last) begin
        busy_r <= 1'b0;
      end
      if (byte_end) begin
        phase_r <= PH_PCT;
      end else begin
        case (phase_r)
          PH_PCT:  phase_r <= PH_HI;
          PH_HI:   phase_r <= PH_LO;
          default: phase_r <= PH_PCT;
        endcase
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (burst_load) begin
      bytes_r <= burst.bytes;
      left_r  <= burst.nbytes;
      done_r  <= burst.done;
    end else if (pop && byte_end && !last) begin
      bytes_r <= {NUL_CHAR, bytes_r[MAX_CHAR-1:1]};
      left_r  <= left_r - 3'd1;
    end
  end

endmodule

FILE: design/budget_capped_percent_encoder.sv
// Path: an accepted byte is registered, then loaded into the result register
//   when the serializer is free, which then presents its first result beat.
// Throughput: one result beat per cycle from the serializer while the receiver is ready;
//   bytes that emit nothing do not wait for it; a passed byte gives 1 beat, an escaped one 3 (up to 12).
// Reset: synchronous, active low; clears counters, flags and valids, budget = 6000.
//   Held character bytes are not cleared; they are never read before written.
module budget_capped_percent_encoder #(
  parameter int COUNT_BITS = pce_pkg::COUNT_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  pce_in_if.sink    in_bus,
  pce_out_if.source out_bus,
  pce_cfg_if.sink   cfg_bus
);
  import pce_pkg::*;

  // Hand-off between the encoder stage and the serializer. The encoder
  // keeps all per-string state (used count, stop flag, held bytes) and
  // updates it as soon as an item leaves its input register; only items
  // that yield beats wait for the serializer to free up.
  logic        burst_load;
  logic        burst_free;
  burst_t      burst;
  enc_status_t enc_st;

  // Grouping and budget test: the input register feeds a short chain of
  // at most three add/compare steps (one per character group), so a new
  // byte can be taken every cycle when it produces no beats.
  pce_encode #(
    .COUNT_BITS (COUNT_BITS)
  ) u_encode (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_bus     (in_bus),
    .cfg_bus    (cfg_bus),
    .burst_free (burst_free),
    .burst_load (burst_load),
    .burst      (burst),
    .status     (enc_st)
  );

  // Result register: holds up to four raw bytes and walks them out as
  // literal characters or as percent plus two hex digits. It frees on the
  // beat that ends the burst, so the next burst follows without a gap.
  pce_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .burst_load (burst_load),
    .burst      (burst),
    .burst_free (burst_free),
    .out_bus    (out_bus)
  );

`ifndef ASSERT_OFF
  // an end-only marker is always the closing beat of its string
  a_marker_closes : assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && !out_bus.char_present |-> out_bus.run_last && out_bus.string_done)
    else $error("marker beat without end flags");

  // a refusal only happens on a whole group, never with bytes still held
  a_stop_no_pending : assert property (@(posedge clk) disable iff (!rst_n)
    enc_st.stopped |-> enc_st.pend_cnt == 2'd0)
    else $error("stop flag set while bytes are held");

  // held bytes are always fewer than the length their lead announced
  a_pending_short : assert property (@(posedge clk) disable iff (!rst_n)
    enc_st.pend_cnt != 2'd0 |-> enc_st.char_len > {1'b0, enc_st.pend_cnt})
    else $error("held bytes reach announced character length");

  // an announced character length is kept only while bytes are held
  a_done_clears : assert property (@(posedge clk) disable iff (!rst_n)
    enc_st.pend_cnt == 2'd0 |-> enc_st.char_len == 3'd0)
    else $error("character length left over without held bytes");
`endif

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for the budget-capped percent encoder.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pce_pkg::*;

  // Clean cycles after the last beat before a budget write or the end.
  localparam int SETTLE_CYCLES = 16;
  // Long receiver hold-off: forces the block to fill up and back-pressure.
  localparam int HOLD_CYCLES   = 200;
  localparam int RAND_PHASES   = 6;
  localparam int BYTES_PER_PHASE = 30;
  localparam int LIMIT_NS      = 5_000_000;
  localparam int unsigned USED_MAX = 32'((64'd1 << COUNT_BITS_DEF) - 64'd1);

  typedef struct packed {
    byte_t ch;
    logic  present;
    logic  run_last;
    logic  done;
  } enc_beat_t;

  // Tracks the encoder state and queues up the output beats each byte produces.
  class pct_enc_tracker;
    logic [BUDGET_W-1:0] budget;
    int unsigned used;
    bit          halted;
    byte_t       held [PEND_DEPTH];
    int          held_cnt;
    int          want_len;
    byte_t       char_buf [MAX_CHAR];
    enc_beat_t   step_beats [$];
    enc_beat_t   expected_chars [$];
    int errors, bytes_in, strings_in, beats_seen, stops, markers;

    function new();
      budget     = BUDGET_RESET;
      used       = 0;
      halted     = 0;
      held_cnt   = 0;
      want_len   = 0;
      errors     = 0;
      bytes_in   = 0;
      strings_in = 0;
      beats_seen = 0;
      stops      = 0;
      markers    = 0;
    endfunction

    static function bit is_safe_char(byte_t c);
      return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
             (c >= "a" && c <= "z") || c == "-" || c == "_" || c == "." || c == "~";
    endfunction

    static function int utf8_len(byte_t c);
      if (!c[7]) return 1;
      if (c[7:5] == 3'b110) return 2;
      if (c[7:4] == 4'b1110) return 3;
      if (c[7:3] == 5'b11110) return 4;
      return 1;
    endfunction

    static function byte_t hex_ascii(logic [3:0] nib);
      return (nib < 4'd10) ? byte_t'(8'h30 + nib) : byte_t'(8'h37 + nib);
    endfunction

    function void push_beat(byte_t c, logic p);
      enc_beat_t bt;
      bt.ch       = c;
      bt.present  = p;
      bt.run_last = 1'b0;
      bt.done     = 1'b0;
      step_beats.push_back(bt);
    endfunction

    // Emit char_buf[first +: n] whole if it fits in the budget, else stop the string.
    function bit try_char(int first, int n);
      int unsigned cost;
      int i;
      cost = 0;
      for (i = first; i < first + n; i++) cost += is_safe_char(char_buf[i]) ? 1 : 3;
      if (used + cost > budget) begin
        halted = 1'b1;
        stops++;
        return 1'b0;
      end
      for (i = first; i < first + n; i++) begin
        if (is_safe_char(char_buf[i])) begin
          push_beat(char_buf[i], 1'b1);
        end else begin
          push_beat(PCT_CHAR, 1'b1);
          push_beat(hex_ascii(char_buf[i][7:4]), 1'b1);
          push_beat(hex_ascii(char_buf[i][3:0]), 1'b1);
        end
      end
      used = (used + cost > USED_MAX) ? USED_MAX : used + cost;
      return 1'b1;
    endfunction

    function void set_budget(logic [BUDGET_W-1:0] v);
      budget = v;
    endfunction

    // Accepted input beat: work out every output beat it causes.
    function void note_byte(byte_t b, logic fin);
      int n, k, i;
      step_beats.delete();
      bytes_in++;
      if (!halted) begin
        if (held_cnt == 0) begin
          n = utf8_len(b);
          if (n == 1) begin
            char_buf[0] = b;
            void'(try_char(0, 1));
          end else begin
            held[0]  = b;
            held_cnt = 1;
            want_len = n;
          end
        end else begin
          for (i = 0; i < held_cnt; i++) char_buf[i] = held[i];
          char_buf[held_cnt] = b;
          k = held_cnt + 1;
          if (k >= want_len) begin
            held_cnt = 0;
            want_len = 0;
            void'(try_char(0, k));
          end else begin
            held[k-1] = b;
            held_cnt  = k;
          end
        end
        // String ended inside a character: regroup the held bytes from the
        // start, anything that would overrun the end goes out as one byte.
        if (fin && held_cnt != 0) begin
          k = held_cnt;
          for (i = 0; i < k; i++) char_buf[i] = held[i];
          i = 0;
          while (i < k) begin
            n = utf8_len(char_buf[i]);
            if (i + n > k) n = 1;
            if (!try_char(i, n)) break;
            i += n;
          end
        end
      end
      if (fin) begin
        if (step_beats.size() == 0) begin
          push_beat(NUL_CHAR, 1'b0);
          markers++;
        end
        step_beats[step_beats.size()-1].done = 1'b1;
        used     = 0;
        halted   = 1'b0;
        held_cnt = 0;
        want_len = 0;
        strings_in++;
      end
      if (step_beats.size() != 0) step_beats[step_beats.size()-1].run_last = 1'b1;
      foreach (step_beats[j]) expected_chars.push_back(step_beats[j]);
    endfunction

    // Accepted output beat: compare with the oldest expected beat.
    function void check_char(byte_t c, logic p, logic rl, logic dn);
      enc_beat_t exp_b;
      beats_seen++;
      if (expected_chars.size() == 0) begin
        $error("unexpected output beat: out_char %h char_present %b run_last %b string_done %b",
               c, p, rl, dn);
        errors++;
        return;
      end
      exp_b = expected_chars.pop_front();
      if (c !== exp_b.ch) begin
        $error("out_char mismatch: expected %h, got %h", exp_b.ch, c);
        errors++;
      end
      if (p !== exp_b.present) begin
        $error("char_present mismatch: expected %b, got %b", exp_b.present, p);
        errors++;
      end
      if (rl !== exp_b.run_last) begin
        $error("run_last mismatch: expected %b, got %b", exp_b.run_last, rl);
        errors++;
      end
      if (dn !== exp_b.done) begin
        $error("string_done mismatch: expected %b, got %b", exp_b.done, dn);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  pce_in_if  in_bus();
  pce_out_if out_bus();
  pce_cfg_if cfg_bus();

  budget_capped_percent_encoder uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  pct_enc_tracker tracker = new();

  byte_t text_q [$];   // bytes of the next string to send
  bit    in_steady;    // sender runs without gaps for this string
  bit    out_steady;   // receiver runs without stalls for this string
  bit    squeeze_req;  // ask the receiver for one long hold-off
  int    budgets_used;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Mostly back-to-back, some short gaps, a few long ones.
  function automatic int idle_len(bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  // Appends one character: plain ASCII, UTF-8 of 1..4 bytes, a broken
  // sequence or noise. With cut set, always a lead byte short of its tail.
  function automatic void add_char(bit cut);
    int r, n, keep, i;
    byte_t b;
    r = cut ? 60 : $urandom_range(0, 99);
    if (r < 30) begin
      do b = byte_t'($urandom_range(8'h2D, 8'h7E)); while (!pct_enc_tracker::is_safe_char(b));
      text_q.push_back(b);
    end else if (r < 50) begin
      text_q.push_back(byte_t'($urandom_range(0, 127)));
    end else if (r < 82) begin
      n = $urandom_range(2, 4);
      case (n)
        2: b = {3'b110, 5'($urandom)};
        3: b = {4'b1110, 4'($urandom)};
        default: b = {5'b11110, 3'($urandom)};
      endcase
      keep = (cut || r >= 76) ? $urandom_range(1, n - 1) : n;
      text_q.push_back(b);
      for (i = 1; i < keep; i++) begin
        if ($urandom_range(0, 99) < 85) text_q.push_back({2'b10, 6'($urandom)});
        else text_q.push_back(byte_t'($urandom));
      end
    end else begin
      text_q.push_back(byte_t'($urandom));
    end
  endfunction

  // One input beat; valid stays high into the next beat when there is no gap.
  task automatic send_byte(input byte_t b, input logic fin);
    int gap;
    gap = idle_len(in_steady);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.in_byte    <= b;
    in_bus.final_byte <= fin;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    tracker.note_byte(b, fin);
  endtask

  task automatic send_text();
    int i;
    in_steady  = ($urandom_range(0, 4) == 0);
    out_steady = ($urandom_range(0, 4) == 0);
    for (i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
  endtask

  // Sender pauses until every expected beat is out, then the block goes quiet.
  task automatic drain();
    in_bus.valid <= 1'b0;
    while (tracker.expected_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Budget writes only happen with the block idle.
  task automatic load_budget(input logic [BUDGET_W-1:0] v);
    cfg_bus.valid         <= 1'b1;
    cfg_bus.output_budget <= v;
    do @(posedge clk); while (cfg_bus.ready !== 1'b1);
    cfg_bus.valid <= 1'b0;
    tracker.set_budget(v);
    budgets_used++;
  endtask

  // Receiver: random stalls, one long hold-off on request.
  initial begin
    int stall;
    out_bus.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (squeeze_req) begin
        stall       = HOLD_CYCLES;
        squeeze_req = 1'b0;
      end else begin
        stall = idle_len(out_steady);
      end
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (out_bus.valid !== 1'b1);
      tracker.check_char(out_bus.out_char, out_bus.char_present,
                         out_bus.run_last, out_bus.string_done);
    end
  end

  // Stimulus
  initial begin
    int p, sent;
    logic [BUDGET_W-1:0] bud;
    rst_n                 = 1'b0;
    in_bus.valid          = 1'b0;
    in_bus.in_byte        = '0;
    in_bus.final_byte     = 1'b0;
    cfg_bus.valid         = 1'b0;
    cfg_bus.output_budget = '0;
    in_steady             = 1'b0;
    out_steady            = 1'b0;
    squeeze_req           = 1'b0;
    budgets_used          = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, reset budget: byte extremes, safe chars, 2/3/4-byte UTF-8,
    // malformed lead, stray continuation, then an end that cuts a 4-byte
    // character short so the held bytes regroup as a lone byte plus a pair.
    text_q = '{8'h00, 8'h2D, 8'h7E, 8'h7F, 8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC,
               8'hF0, 8'h9F, 8'h98, 8'h80, 8'hFF, 8'h80, 8'h5A,
               8'hF0, 8'hC3, 8'hA9};
    send_text();
    drain();

    // Zero budget: nothing fits, so the end produces only the marker beat.
    load_budget(16'd0);
    text_q = '{8'h61};
    send_text();
    drain();

    // Budget of 5: fill exactly, refuse the next char, ignore the rest,
    // and close with a marker after earlier output.
    load_budget(16'd5);
    text_q = '{8'h61, 8'h20, 8'h62, 8'h63, 8'h41};
    send_text();
    drain();

    // Random strings over several budgets, extremes included.
    for (p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: bud = 16'hFFFF;
        1: bud = 16'($urandom_range(0, 8));
        2: bud = 16'($urandom_range(10, 60));
        3: bud = 16'd1;
        4: bud = 16'($urandom);
        default: bud = 16'($urandom_range(20, 90));
      endcase
      load_budget(bud);
      if (p == 0) squeeze_req = 1'b1;
      sent = 0;
      while (sent < BYTES_PER_PHASE) begin
        text_q.delete();
        repeat ($urandom_range(1, 8)) add_char(1'b0);
        if ($urandom_range(0, 4) == 0) add_char(1'b1);
        send_text();
        sent += text_q.size();
      end
      drain();
    end

    if (tracker.expected_chars.size() != 0) begin
      $error("%0d expected output beats never arrived", tracker.expected_chars.size());
      tracker.errors++;
    end
    $display("Covered %0d input bytes in %0d strings under %0d budget settings.",
             tracker.bytes_in, tracker.strings_in, budgets_used);
    $display("Checked %0d output beats: %0d budget stops, %0d end-only markers.",
             tracker.beats_seen, tracker.stops, tracker.markers);
    if (tracker.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #LIMIT_NS;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
